// ----- src/njs_pkg.sv -----
// ============================================================================
// njs_pkg
// Shared constants, widths and types of the non-preemptive job scheduler.
// ============================================================================
package njs_pkg;

    // Job store size and the index and count widths that follow from it.
    localparam int MAX_JOBS = 16;
    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);

    // Field widths.
    localparam int ARRIVAL_W   = 16;
    localparam int BURST_W     = 12;
    localparam int PRIO_W      = 8;
    localparam int TIME_W      = 18;
    localparam int MODE_W      = 2;
    localparam int JOB_INDEX_W = 4;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Policy codes. The spare code is served as first come first serve.
    localparam logic [MODE_W-1:0] POLICY_FCFS = 2'd0;
    localparam logic [MODE_W-1:0] POLICY_SJF  = 2'd1;
    localparam logic [MODE_W-1:0] POLICY_PRIO = 2'd2;

    // One job as it travels from the front to the back.
    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [BURST_W-1:0]   burst;
        logic [PRIO_W-1:0]    prio;
        logic                 last;
        logic                 keep;
        logic [IDX_W-1:0]     slot;
    } job_entry_t;

    // Queue status seen by the two sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- src/njs_ifs.sv -----
// ============================================================================
// njs_ifs
// Channel interfaces: job input, result output and policy write.
// ============================================================================
interface njs_job_if import njs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ARRIVAL_W-1:0] arrival_time;
    logic [BURST_W-1:0]   burst_time;
    logic [PRIO_W-1:0]    priority_level;
    logic                 last_job;

    modport source (output valid, arrival_time, burst_time, priority_level, last_job,
                    input ready);
    modport sink   (input valid, arrival_time, burst_time, priority_level, last_job,
                    output ready);
endinterface

interface njs_res_if import njs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [JOB_INDEX_W-1:0] job_index;
    logic [TIME_W-1:0]      completion_time;
    logic [TIME_W-1:0]      turnaround_time;
    logic [TIME_W-1:0]      waiting_time;
    logic                   last_result;

    modport source (output valid, job_index, completion_time, turnaround_time,
                    waiting_time, last_result, input ready);
    modport sink   (input valid, job_index, completion_time, turnaround_time,
                    waiting_time, last_result, output ready);
endinterface

interface njs_cfg_if import njs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- src/nonpreemptive_job_scheduler.sv -----
// ============================================================================
// nonpreemptive_job_scheduler
// Batch job scheduler with FCFS, shortest-job-first and priority policies.
// ============================================================================
// Usage: jobs arrive on the jobs channel, one transfer per job. A transfer
// with last_job set closes the batch; at most 16 jobs are kept and further
// jobs of the batch are dropped. The cfg channel writes policy_mode
// (0 first come first serve, 1 shortest job first, 2 priority, 3 as 0) and
// is always ready; write it only while the block is idle.
// The front accepts a job every cycle while the four-entry queue has room,
// so loading runs at one job per cycle while the back is in its load state,
// and jobs of the next batch can queue while the current one is reported.
// Scheduling: for a batch of n jobs, each of the n selections scans the job
// memory one entry per cycle through its single read port and then commits
// the pick. Results then leave in index order; each one is read, computed
// and held in the result register until the receiver takes it.
// A stalled receiver holds the result register and the back; the front keeps
// filling the queue until it is full, then drops jobs.ready.
// Reset clears the job count, the schedule state, the policy (to first come
// first serve) and the queue; no clearing pass is needed.
// ============================================================================
module nonpreemptive_job_scheduler import njs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    njs_cfg_if.sink    cfg,
    njs_job_if.sink    jobs,
    njs_res_if.source  results
);

    logic [MODE_W-1:0] policy_mode_reg;
    logic [MODE_W-1:0] policy_mode_next;
    logic              q_push;
    logic              q_pop;
    job_entry_t        push_entry;
    job_entry_t        pop_entry;
    queue_status_t     q_status;

    // The policy register takes every write transfer.
    assign cfg.ready        = 1'b1;
    assign policy_mode_next = (cfg.valid && cfg.ready) ? cfg.data : policy_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_mode_reg <= POLICY_FCFS;
        end
        else
        begin
            policy_mode_reg <= policy_mode_next;
        end
    end

    // Front: accepts jobs, numbers their slots and flags overflow.
    njs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .jobs     (jobs),
        .q_status (q_status),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    // Queue that lets the front keep loading while the back is busy.
    njs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    // Back: stores the batch, schedules it and reports every job.
    njs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .policy_mode (policy_mode_reg),
        .q_status    (q_status),
        .q_entry     (pop_entry),
        .q_pop       (q_pop),
        .results     (results)
    );

endmodule

// ----- src/njs_front.sv -----
// ============================================================================
// njs_front
// Accepts jobs, assigns each a store slot, marks overflow jobs for dropping.
// ============================================================================
module njs_front import njs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    njs_job_if.sink       jobs,
    input  queue_status_t q_status,
    output logic          q_push,
    output job_entry_t    q_entry
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             keep;

    assign jobs.ready = !q_status.full;
    assign q_push     = jobs.valid && jobs.ready;
    assign keep       = (cnt_reg < CNT_W'(MAX_JOBS));

    assign q_entry.arrival = jobs.arrival_time;
    assign q_entry.burst   = jobs.burst_time;
    assign q_entry.prio    = jobs.priority_level;
    assign q_entry.last    = jobs.last_job;
    assign q_entry.keep    = keep;
    assign q_entry.slot    = cnt_reg[IDX_W-1:0];

    // The batch count restarts after the closing job.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (q_push)
        begin
            if (jobs.last_job)
            begin
                cnt_next = '0;
            end
            else if (keep)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- src/njs_queue.sv -----
// ============================================================================
// njs_queue
// Short first-in first-out queue of classified jobs between front and back.
// ============================================================================
module njs_queue import njs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_entry_t    push_entry,
    input  logic          pop,
    output job_entry_t    pop_entry,
    output queue_status_t status
);

    job_entry_t        entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_entry    = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- src/njs_back.sv -----
// ============================================================================
// njs_back
// Stores the batch, runs the non-preemptive schedule and reports each job.
// ============================================================================
module njs_back import njs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [MODE_W-1:0] policy_mode,
    input  queue_status_t     q_status,
    input  job_entry_t        q_entry,
    output logic              q_pop,
    njs_res_if.source         results
);

    typedef enum logic [5:0] {
        ST_LOAD     = 6'b000001,
        ST_SCAN     = 6'b000010,
        ST_COMMIT   = 6'b000100,
        ST_OUT_READ = 6'b001000,
        ST_OUT_CALC = 6'b010000,
        ST_OUT_WAIT = 6'b100000
    } back_state_t;

    // Candidate ordering for the shortest job and priority policies.
    function automatic logic better(input logic sjf,
                                    input logic [BURST_W-1:0] c_bur,
                                    input logic [PRIO_W-1:0] c_pri,
                                    input logic [ARRIVAL_W-1:0] c_arr,
                                    input logic [BURST_W-1:0] b_bur,
                                    input logic [PRIO_W-1:0] b_pri,
                                    input logic [ARRIVAL_W-1:0] b_arr);
        logic res;
        if (sjf)
        begin
            res = (c_bur < b_bur);
        end
        else
        begin
            res = (c_pri < b_pri) || ((c_pri == b_pri) && (c_arr < b_arr));
        end
        return res;
    endfunction

    // Job memories.
    logic [ARRIVAL_W-1:0] arr_mem [MAX_JOBS];
    logic [BURST_W-1:0]   bur_mem [MAX_JOBS];
    logic [PRIO_W-1:0]    pri_mem [MAX_JOBS];
    logic [TIME_W-1:0]    fin_mem [MAX_JOBS];
    logic [ARRIVAL_W-1:0] rd_arr_q;
    logic [BURST_W-1:0]   rd_bur_q;
    logic [PRIO_W-1:0]    rd_pri_q;
    logic [TIME_W-1:0]    rd_fin_q;

    back_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic [TIME_W-1:0]    clock_reg, clock_next;
    logic [MAX_JOBS-1:0]  done_reg, done_next;

    // Best arrived candidate (a) and best among the earliest pending (e).
    logic                 have_a_reg, have_a_next;
    logic [IDX_W-1:0]     a_idx_reg, a_idx_next;
    logic [ARRIVAL_W-1:0] a_arr_reg, a_arr_next;
    logic [BURST_W-1:0]   a_bur_reg, a_bur_next;
    logic [PRIO_W-1:0]    a_pri_reg, a_pri_next;
    logic                 have_e_reg, have_e_next;
    logic [IDX_W-1:0]     e_idx_reg, e_idx_next;
    logic [ARRIVAL_W-1:0] e_arr_reg, e_arr_next;
    logic [BURST_W-1:0]   e_bur_reg, e_bur_next;
    logic [PRIO_W-1:0]    e_pri_reg, e_pri_next;

    // Result register.
    logic                   res_valid_reg, res_valid_next;
    logic [JOB_INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic [TIME_W-1:0]      res_ct_reg, res_ct_next;
    logic [TIME_W-1:0]      res_tat_reg, res_tat_next;
    logic [TIME_W-1:0]      res_wt_reg, res_wt_next;
    logic                   res_last_reg, res_last_next;

    logic                 fcfs, sjf;
    logic                 mem_wr, fin_wr;
    logic [IDX_W-1:0]     rd_addr;
    logic                 issue, pend, elig_a, take_a, take_e;
    logic [IDX_W-1:0]     pick_idx;
    logic [ARRIVAL_W-1:0] pick_arr;
    logic [BURST_W-1:0]   pick_bur;
    logic [TIME_W-1:0]    start_time, fin_time;
    logic [CNT_W-1:0]     k_inc, rd_inc;
    logic [TIME_W-1:0]    tat_calc;

    assign fcfs    = !((policy_mode == POLICY_SJF) || (policy_mode == POLICY_PRIO));
    assign sjf     = (policy_mode == POLICY_SJF);
    assign rd_addr = rd_idx_reg[IDX_W-1:0];
    assign issue   = (rd_idx_reg < n_reg);
    assign k_inc   = k_reg + CNT_W'(1);
    assign rd_inc  = rd_idx_reg + CNT_W'(1);

    // Scan evaluation of the entry read in the previous cycle.
    assign pend   = !done_reg[pipe_idx_reg];
    assign elig_a = pend && (fcfs || (TIME_W'(rd_arr_q) <= clock_reg));
    assign take_a = elig_a && (!have_a_reg || (!fcfs &&
                    better(sjf, rd_bur_q, rd_pri_q, rd_arr_q,
                           a_bur_reg, a_pri_reg, a_arr_reg)));
    assign take_e = pend && !fcfs && (!have_e_reg || (rd_arr_q < e_arr_reg) ||
                    ((rd_arr_q == e_arr_reg) &&
                     better(sjf, rd_bur_q, rd_pri_q, rd_arr_q,
                            e_bur_reg, e_pri_reg, e_arr_reg)));

    // An arrived job starts at the clock; otherwise the clock jumps ahead.
    assign pick_idx   = have_a_reg ? a_idx_reg : e_idx_reg;
    assign pick_arr   = have_a_reg ? a_arr_reg : e_arr_reg;
    assign pick_bur   = have_a_reg ? a_bur_reg : e_bur_reg;
    assign start_time = (clock_reg > TIME_W'(pick_arr)) ? clock_reg : TIME_W'(pick_arr);
    assign fin_time   = start_time + TIME_W'(pick_bur);

    assign tat_calc = rd_fin_q - TIME_W'(rd_arr_q);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        rd_idx_next    = rd_idx_reg;
        pipe_vld_next  = 1'b0;
        pipe_idx_next  = rd_addr;
        clock_next     = clock_reg;
        done_next      = done_reg;
        have_a_next    = have_a_reg;
        a_idx_next     = a_idx_reg;
        a_arr_next     = a_arr_reg;
        a_bur_next     = a_bur_reg;
        a_pri_next     = a_pri_reg;
        have_e_next    = have_e_reg;
        e_idx_next     = e_idx_reg;
        e_arr_next     = e_arr_reg;
        e_bur_next     = e_bur_reg;
        e_pri_next     = e_pri_reg;
        res_valid_next = res_valid_reg;
        res_idx_next   = res_idx_reg;
        res_ct_next    = res_ct_reg;
        res_tat_next   = res_tat_reg;
        res_wt_next    = res_wt_reg;
        res_last_next  = res_last_reg;
        q_pop          = 1'b0;
        mem_wr         = 1'b0;
        fin_wr         = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                q_pop  = !q_status.empty;
                mem_wr = q_pop && q_entry.keep;
                if (q_pop && q_entry.last)
                begin
                    n_next      = q_entry.keep ? (CNT_W'(q_entry.slot) + CNT_W'(1))
                                               : CNT_W'(MAX_JOBS);
                    k_next      = '0;
                    rd_idx_next = '0;
                    clock_next  = '0;
                    done_next   = '0;
                    have_a_next = 1'b0;
                    have_e_next = 1'b0;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                pipe_vld_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_inc;
                end
                if (pipe_vld_reg)
                begin
                    if (take_a)
                    begin
                        have_a_next = 1'b1;
                        a_idx_next  = pipe_idx_reg;
                        a_arr_next  = rd_arr_q;
                        a_bur_next  = rd_bur_q;
                        a_pri_next  = rd_pri_q;
                    end
                    if (take_e)
                    begin
                        have_e_next = 1'b1;
                        e_idx_next  = pipe_idx_reg;
                        e_arr_next  = rd_arr_q;
                        e_bur_next  = rd_bur_q;
                        e_pri_next  = rd_pri_q;
                    end
                end
                if (!issue && !pipe_vld_reg)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                fin_wr              = 1'b1;
                clock_next          = fin_time;
                done_next[pick_idx] = 1'b1;
                k_next              = k_inc;
                rd_idx_next         = '0;
                have_a_next         = 1'b0;
                have_e_next         = 1'b0;
                state_next          = (k_inc == n_reg) ? ST_OUT_READ : ST_SCAN;
            end
            ST_OUT_READ:
            begin
                state_next = ST_OUT_CALC;
            end
            ST_OUT_CALC:
            begin
                res_valid_next = 1'b1;
                res_idx_next   = JOB_INDEX_W'(rd_idx_reg);
                res_ct_next    = rd_fin_q;
                res_tat_next   = tat_calc;
                res_wt_next    = tat_calc - TIME_W'(rd_bur_q);
                res_last_next  = (rd_inc == n_reg);
                state_next     = ST_OUT_WAIT;
            end
            ST_OUT_WAIT:
            begin
                if (results.ready)
                begin
                    res_valid_next = 1'b0;
                    rd_idx_next    = rd_inc;
                    state_next     = res_last_reg ? ST_LOAD : ST_OUT_READ;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Memories: one write port each, registered read at the shared address.
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            arr_mem[q_entry.slot] <= q_entry.arrival;
            bur_mem[q_entry.slot] <= q_entry.burst;
            pri_mem[q_entry.slot] <= q_entry.prio;
        end
        if (fin_wr)
        begin
            fin_mem[pick_idx] <= fin_time;
        end
        rd_arr_q <= arr_mem[rd_addr];
        rd_bur_q <= bur_mem[rd_addr];
        rd_pri_q <= pri_mem[rd_addr];
        rd_fin_q <= fin_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            n_reg         <= '0;
            k_reg         <= '0;
            rd_idx_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            clock_reg     <= '0;
            done_reg      <= '0;
            have_a_reg    <= 1'b0;
            have_e_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            rd_idx_reg    <= rd_idx_next;
            pipe_vld_reg  <= pipe_vld_next;
            clock_reg     <= clock_next;
            done_reg      <= done_next;
            have_a_reg    <= have_a_next;
            have_e_reg    <= have_e_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= pipe_idx_next;
        a_idx_reg    <= a_idx_next;
        a_arr_reg    <= a_arr_next;
        a_bur_reg    <= a_bur_next;
        a_pri_reg    <= a_pri_next;
        e_idx_reg    <= e_idx_next;
        e_arr_reg    <= e_arr_next;
        e_bur_reg    <= e_bur_next;
        e_pri_reg    <= e_pri_next;
        res_idx_reg  <= res_idx_next;
        res_ct_reg   <= res_ct_next;
        res_tat_reg  <= res_tat_next;
        res_wt_reg   <= res_wt_next;
        res_last_reg <= res_last_next;
    end

    assign results.valid           = res_valid_reg;
    assign results.job_index       = res_idx_reg;
    assign results.completion_time = res_ct_reg;
    assign results.turnaround_time = res_tat_reg;
    assign results.waiting_time    = res_wt_reg;
    assign results.last_result     = res_last_reg;

`ifndef SYNTHESIS
    // Every commit has a candidate, and it is a job not yet scheduled.
    a_commit_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> (have_a_reg || have_e_reg))
        else $error("commit without a candidate job");

    a_commit_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMMIT) |-> !done_reg[pick_idx])
        else $error("commit picked a job that already ran");

    // The final result transfer returns the back to loading.
    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_result)
        |=> (state_reg == ST_LOAD))
        else $error("final result did not end the batch");

    // The queue is only drained while loading.
    a_pop_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> ((state_reg == ST_LOAD) && !q_status.empty))
        else $error("queue popped outside loading");
`endif

endmodule

// ----- sim/nonpreemptive_job_scheduler_test.sv -----
// ============================================================================
// nonpreemptive_job_scheduler_test
// Self-checking bench for the batch job scheduler. Batches of jobs are sent
// over the jobs channel under each policy setting. Every transfer is fed to
// a scheduler model inside the bench, and each result transfer is compared
// field by field with the oldest predicted report.
// ============================================================================
module nonpreemptive_job_scheduler_test;

    timeunit 1ns;
    timeprecision 1ps;

    import njs_pkg::*;

    // The spare policy code has no name in the package; the block serves it
    // as first come first serve.
    localparam logic [MODE_W-1:0] POLICY_SPARE = 2'd3;

    // Rough number of jobs to send over the whole run.
    localparam int TARGET_JOBS = 330;

    // Length of the receiver hold-off that forces the block to back up.
    localparam int HOLD_CYCLES = 320;

    // Hard stop for a hung run, in ns.
    localparam int RUN_LIMIT_NS = 400000;

    // One job as sent on the jobs channel.
    typedef struct packed {
        logic [ARRIVAL_W-1:0] arrival;
        logic [BURST_W-1:0]   burst;
        logic [PRIO_W-1:0]    prio;
        logic                 last;
    } job_item_t;

    // One predicted report as it should appear on the results channel.
    typedef struct packed {
        logic [JOB_INDEX_W-1:0] job_index;
        logic [TIME_W-1:0]      completion_time;
        logic [TIME_W-1:0]      turnaround_time;
        logic [TIME_W-1:0]      waiting_time;
        logic                   last_result;
    } job_report_t;

    logic clk;
    logic rst_n;

    njs_cfg_if cfg_ch ();
    njs_job_if job_ch ();
    njs_res_if res_ch ();

    nonpreemptive_job_scheduler uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .jobs    (job_ch),
        .results (res_ch)
    );

    // Jobs waiting to be offered, and reports the scheduler still owes us.
    job_item_t   jobs_to_send [$];
    job_report_t reports_due [$];

    // Scheduler model state: the job store of the current batch and the
    // policy that was last written to the block.
    job_item_t         batch_jobs [MAX_JOBS];
    int                batch_size;
    logic [MODE_W-1:0] active_policy;

    job_item_t on_offer;
    int        send_gap;
    int        take_gap;
    int        queued_jobs;
    int        mismatch_count;
    bit        steady_send;
    bit        steady_take;
    bit        squeeze_start;
    logic      hold_off;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Scheduler model
    // ------------------------------------------------------------------------

    // Stores one accepted job. A job that finds the store full is dropped,
    // but if it closes the batch the schedule still runs on what is stored.
    // On the closing job the whole non-preemptive schedule is worked out and
    // one report per stored job is queued, in load order.
    task automatic take_job(input job_item_t job);
        logic [TIME_W-1:0] finish_at [MAX_JOBS];
        bit                served [MAX_JOBS];
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] earliest;
        job_report_t       report;
        int                pick;
        int                i;
        int                k;
        bit                found;
        bit                pending;
        begin
            if (batch_size < MAX_JOBS)
            begin
                batch_jobs[batch_size] = job;
                batch_size++;
            end
            if (job.last)
            begin
                now = '0;
                for (i = 0; i < MAX_JOBS; i++)
                begin
                    served[i]    = 1'b0;
                    finish_at[i] = '0;
                end

                for (k = 0; k < batch_size; k++)
                begin
                    pick = 0;
                    if (active_policy == POLICY_SJF || active_policy == POLICY_PRIO)
                    begin
                        // When nothing pending has arrived yet, time jumps
                        // ahead to the earliest pending arrival.
                        pending  = 1'b0;
                        earliest = '0;
                        for (i = 0; i < batch_size; i++)
                        begin
                            if (!served[i] &&
                                (!pending || TIME_W'(batch_jobs[i].arrival) < earliest))
                            begin
                                earliest = TIME_W'(batch_jobs[i].arrival);
                                pending  = 1'b1;
                            end
                        end
                        if (pending && now < earliest)
                            now = earliest;

                        // Among arrived jobs: shortest burst, or lowest
                        // priority value with the earlier arrival breaking
                        // ties. Remaining ties keep the lower index.
                        found = 1'b0;
                        for (i = 0; i < batch_size; i++)
                        begin
                            if (served[i] || TIME_W'(batch_jobs[i].arrival) > now)
                                continue;
                            if (!found)
                            begin
                                pick  = i;
                                found = 1'b1;
                            end
                            else if (active_policy == POLICY_SJF)
                            begin
                                if (batch_jobs[i].burst < batch_jobs[pick].burst)
                                    pick = i;
                            end
                            else if (batch_jobs[i].prio < batch_jobs[pick].prio)
                                pick = i;
                            else if (batch_jobs[i].prio == batch_jobs[pick].prio &&
                                     batch_jobs[i].arrival < batch_jobs[pick].arrival)
                                pick = i;
                        end
                    end
                    else
                    begin
                        // First come first serve, also used for the spare
                        // code: simply the next job in load order.
                        found = 1'b0;
                        for (i = 0; i < batch_size; i++)
                        begin
                            if (!found && !served[i])
                            begin
                                pick  = i;
                                found = 1'b1;
                            end
                        end
                    end

                    if (now < TIME_W'(batch_jobs[pick].arrival))
                        now = TIME_W'(batch_jobs[pick].arrival);
                    now             = now + TIME_W'(batch_jobs[pick].burst);
                    finish_at[pick] = now;
                    served[pick]    = 1'b1;
                end

                for (i = 0; i < batch_size; i++)
                begin
                    report.job_index       = JOB_INDEX_W'(i);
                    report.completion_time = finish_at[i];
                    report.turnaround_time = finish_at[i] - TIME_W'(batch_jobs[i].arrival);
                    report.waiting_time    = report.turnaround_time -
                                             TIME_W'(batch_jobs[i].burst);
                    report.last_result     = (i == batch_size - 1);
                    reports_due.push_back(report);
                end
                batch_size = 0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        begin
            $display("%0t ns: %s", $realtime, what);
            mismatch_count++;
        end
    endtask

    task automatic check_field(input string field, input int unsigned got,
                               input int unsigned want, input int unsigned idx);
        begin
            if (got != want)
                report_mismatch($sformatf("job %0d %s is %0d, %0d predicted",
                                          idx, field, got, want));
        end
    endtask

    // Idle gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(input bit steady);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (steady || r < 55)
                return 0;
            if (r < 90)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Job driver: offers queued jobs, holding each one until it is taken.
    // Every transfer goes straight into the scheduler model.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_ch.valid <= 1'b0;
            send_gap     <= 0;
        end
        else if (!job_ch.valid || job_ch.ready)
        begin
            if (job_ch.valid)
                take_job(on_offer);
            if (send_gap != 0)
            begin
                send_gap     <= send_gap - 1;
                job_ch.valid <= 1'b0;
            end
            else if (jobs_to_send.size() != 0)
            begin
                on_offer = jobs_to_send.pop_front();
                job_ch.arrival_time   <= on_offer.arrival;
                job_ch.burst_time     <= on_offer.burst;
                job_ch.priority_level <= on_offer.prio;
                job_ch.last_job       <= on_offer.last;
                job_ch.valid          <= 1'b1;
                send_gap              <= pick_gap(steady_send);
            end
            else
            begin
                job_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each result transfer against the oldest report
    // still owed, and throttles ready with random stalls.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        job_report_t want;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            take_gap     <= 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    report_mismatch($sformatf("job %0d reported with no result outstanding",
                                              res_ch.job_index));
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("job_index", res_ch.job_index, want.job_index,
                                want.job_index);
                    check_field("completion_time", res_ch.completion_time,
                                want.completion_time, want.job_index);
                    check_field("turnaround_time", res_ch.turnaround_time,
                                want.turnaround_time, want.job_index);
                    check_field("waiting_time", res_ch.waiting_time,
                                want.waiting_time, want.job_index);
                    check_field("last_result", res_ch.last_result,
                                want.last_result, want.job_index);
                end
            end

            if (hold_off)
                res_ch.ready <= 1'b0;
            else if (take_gap != 0)
            begin
                take_gap     <= take_gap - 1;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                take_gap     <= pick_gap(steady_take);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Back-pressure: once asked, the receiver refuses results for a long
    // stretch while the sender keeps offering jobs. The block's queue then
    // fills up and it has to drop ready on the jobs channel.
    // ------------------------------------------------------------------------
    initial
    begin : squeeze
        hold_off = 1'b0;
        wait (squeeze_start);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_job(input int unsigned arrival, input int unsigned burst,
                           input int unsigned prio, input bit last);
        job_item_t job;
        begin
            job.arrival = ARRIVAL_W'(arrival);
            job.burst   = BURST_W'(burst);
            job.prio    = PRIO_W'(prio);
            job.last    = last;
            jobs_to_send.push_back(job);
            queued_jobs++;
        end
    endtask

    // A batch with random content. Arrivals are mostly close together so
    // that several jobs compete at once, bursts are mostly short and
    // priorities mostly few, so ties are common; full-range values are mixed
    // in so that every field bit gets exercised.
    task automatic queue_batch(input int size);
        int          k;
        int unsigned arrival;
        int unsigned burst;
        int unsigned prio;
        int          r;
        begin
            for (k = 0; k < size; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    arrival = $urandom_range(0, 60);
                else if (r < 8)
                    arrival = $urandom_range(0, 2000);
                else
                    arrival = $urandom_range(0, 65535);
                burst = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 4095);
                prio  = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 3)
                                                   : $urandom_range(0, 255);
                add_job(arrival, burst, prio, k == size - 1);
            end
        end
    endtask

    // Batch size: mostly small, sometimes up to the store size, and now and
    // then larger so that the extra jobs are dropped.
    function automatic int pick_batch_size();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                return $urandom_range(1, 6);
            if (r < 93)
                return $urandom_range(7, MAX_JOBS);
            return $urandom_range(MAX_JOBS + 1, MAX_JOBS + 4);
        end
    endfunction

    function automatic logic [MODE_W-1:0] policy_for_phase(input int phase);
        begin
            case (phase % 4)
                0:       return POLICY_FCFS;
                1:       return POLICY_SJF;
                2:       return POLICY_PRIO;
                default: return POLICY_SPARE;
            endcase
        end
    endfunction

    // Waits until every queued job has been taken and every owed report has
    // come back, then lets the block settle.
    task automatic settle();
        begin
            do
                @(negedge clk);
            while (jobs_to_send.size() != 0 || job_ch.valid || reports_due.size() != 0);
            repeat (6) @(posedge clk);
        end
    endtask

    // Writes the policy register; only called while the block is idle.
    task automatic set_policy(input logic [MODE_W-1:0] mode);
        begin
            @(posedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= mode;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            cfg_ch.valid  <= 1'b0;
            active_policy = mode;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int phase;
        int k;

        // Every input is known from time zero.
        rst_n                 = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.data           = POLICY_FCFS;
        job_ch.valid          = 1'b0;
        job_ch.arrival_time   = '0;
        job_ch.burst_time     = '0;
        job_ch.priority_level = '0;
        job_ch.last_job       = 1'b0;
        res_ch.ready          = 1'b0;
        on_offer              = '0;
        batch_size            = 0;
        active_policy         = POLICY_FCFS;
        queued_jobs           = 0;
        mismatch_count        = 0;
        steady_send           = 1'b0;
        steady_take           = 1'b0;
        squeeze_start         = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. First come first serve: a single job at the top of
        // every field range, a single all-zero job, then a batch loaded out
        // of arrival order with an idle stretch before the last job.
        set_policy(POLICY_FCFS);
        add_job(16'hFFFF, 12'hFFF, 8'hFF, 1'b1);
        add_job(0, 0, 0, 1'b1);
        add_job(10, 5, 7, 1'b0);
        add_job(0, 3, 1, 1'b0);
        add_job(40, 2, 0, 1'b1);
        settle();

        // Shortest job first: nothing has arrived at time zero so the clock
        // jumps ahead, two equal bursts tie and the lower index wins, and the
        // last job arrives long after the others are done.
        set_policy(POLICY_SJF);
        add_job(5, 8, 0, 1'b0);
        add_job(6, 3, 0, 1'b0);
        add_job(7, 3, 0, 1'b0);
        add_job(200, 1, 0, 1'b1);
        settle();

        // Priority: equal priorities resolved first by the earlier arrival,
        // then by the lower index, plus a late job with the best priority.
        set_policy(POLICY_PRIO);
        add_job(0, 3, 2, 1'b0);
        add_job(2, 5, 1, 1'b0);
        add_job(1, 4, 1, 1'b0);
        add_job(1, 6, 1, 1'b0);
        add_job(300, 1, 0, 1'b1);
        settle();

        // The spare policy code must behave as first come first serve.
        set_policy(POLICY_SPARE);
        add_job(100, 7, 9, 1'b0);
        add_job(0, 2, 3, 1'b1);
        settle();

        // Random part: phases cycle through all policy codes. The first phase
        // opens with an overfull batch whose closing job is itself dropped;
        // one phase streams jobs while the receiver is held off.
        phase = 0;
        while (queued_jobs < TARGET_JOBS)
        begin
            set_policy(policy_for_phase(phase));
            steady_send = ($urandom_range(0, 3) == 0);
            steady_take = ($urandom_range(0, 3) == 0);
            if (phase == 0)
                queue_batch(MAX_JOBS + 2);
            if (phase == 5)
            begin
                steady_send   = 1'b1;
                steady_take   = 1'b0;
                squeeze_start = 1'b1;
                for (k = 0; k < 3; k++)
                    queue_batch(10);
            end
            else
            begin
                repeat ($urandom_range(2, 4)) queue_batch(pick_batch_size());
            end
            settle();
            phase++;
        end

        // Everything owed has arrived; give any stray result time to show.
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // A run that hangs, for instance on a missing result, ends here.
    initial
    begin : watchdog
        #RUN_LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

endmodule
